// File: src/usv_pkg.sv
// shared types and constants of the utf-8 stream validator
package usv_pkg;

  localparam logic [7:0] BYTE_TERM     = 8'h00;
  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_TILDE    = 8'h7E;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD3_SURR    = 8'hED;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hBF;
  localparam logic [7:0] CONT3_HI_MIN  = 8'hA0;
  localparam logic [7:0] CONT4_HI_MIN  = 8'h90;
  localparam logic [7:0] CONT3_LO_MAX  = 8'h9F;
  localparam logic [7:0] CONT4_LO_MAX  = 8'h8F;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  // allowed range of the next continuation byte
  typedef enum logic [1:0] {
    RANGE_PLAIN = 2'd0,
    RANGE_HIGH  = 2'd1,
    RANGE_LOW   = 2'd2
  } range_e;

  typedef struct packed {
    logic [1:0] bytes_pending;
    range_e     range_code;
    logic       error_seen;
  } usv_state_t;

endpackage

// File: src/utf8_stream_validator.sv
// top level of the utf-8 stream validator
//
// Checks a zero-terminated byte string as strict UTF-8 limited to printable
// text (tab, LF and CR are the only ASCII control characters allowed; DEL,
// overlong forms, surrogates and code points above U+10FFFF fail). Bytes enter
// one per item on the data channel; the block sustains one byte per clock
// except while a terminator waits for the result register. Only the zero
// terminator produces an item on the result channel: string_valid_o is 1 when
// the string just ended was well formed (an empty string counts as valid),
// and the checker state is cleared for the next string. A taken terminator
// passes from the input register into the result register, which offers the
// verdict on the result channel. The running state (continuation bytes
// pending, allowed range of the next continuation byte, sticky error) is
// updated once per byte as the byte leaves the input register. A terminator
// waits in the input register only while the result register still holds an
// untaken verdict; ordinary bytes never wait on the result side.
module utf8_stream_validator
  import usv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte channel
  input  logic       data_valid_i,
  input  logic [7:0] data_byte_i,
  output logic       data_stall_o,
  // verdict channel
  output logic       result_valid_o,
  output logic       string_valid_o,
  input  logic       result_stall_i
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // checker state
  usv_state_t state_q, state_d, step_state;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       verdict_q, verdict_d;

  logic is_term;
  logic verdict;
  logic out_free;
  logic advance;
  logic accept;

  usv_step u_step (
    .data_byte_i (in_byte_q),
    .state_i     (state_q),
    .state_o     (step_state),
    .is_term_o   (is_term),
    .verdict_o   (verdict)
  );

  // result slot is free if empty or being taken this cycle
  assign out_free = !out_valid_q || !result_stall_i;
  // the held byte moves on unless it is a terminator with nowhere to go
  assign advance  = in_valid_q && (!is_term || out_free);

  assign data_stall_o = in_valid_q && !advance;
  assign accept       = data_valid_i && !data_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (!data_stall_o) begin
      in_valid_d = data_valid_i;
    end
  end

  // state moves only with a byte leaving the input register
  assign state_d = advance ? step_state : state_q;

  always_comb begin
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (advance && is_term) begin
      out_valid_d = 1'b1;
      verdict_d   = verdict;
    end else if (!result_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{bytes_pending: PEND_NONE, range_code: RANGE_PLAIN, error_seen: 1'b0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= data_byte_i;
    end
    verdict_q <= verdict_d;
  end

  assign result_valid_o = out_valid_q;
  assign string_valid_o = verdict_q;

  // a terminator that leaves the input register shows up as a result next cycle
  a_term_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_term) |=> out_valid_q)
    else $error("terminator did not produce a result");

  // state is clean after a terminator
  a_term_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_term) |=>
      (state_q.bytes_pending == PEND_NONE && state_q.range_code == RANGE_PLAIN &&
       !state_q.error_seen))
    else $error("state not cleared after terminator");

  // an error leaves nothing pending
  a_error_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error_seen |->
      (state_q.bytes_pending == PEND_NONE && state_q.range_code == RANGE_PLAIN))
    else $error("pending bytes alongside error");

  // a narrowed range only exists right after a three- or four-byte lead
  a_range_needs_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.range_code != RANGE_PLAIN) |->
      (state_q.bytes_pending == PEND_TWO || state_q.bytes_pending == PEND_THREE))
    else $error("range code without multi-byte lead");

  // a held result is not overwritten while stalled
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_stall_i) |=> (out_valid_q && $stable(verdict_q)))
    else $error("stalled verdict changed");

endmodule

// File: src/usv_step.sv
// per-byte state update and verdict of the utf-8 checker
module usv_step
  import usv_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  usv_state_t state_i,
  output usv_state_t state_o,
  output logic       is_term_o,
  output logic       verdict_o
);

  logic [7:0] cont_lo;
  logic [7:0] cont_hi;
  logic       cont_ok;
  logic       plain_ok;
  logic       four_byte;

  assign four_byte = (state_i.bytes_pending == PEND_THREE);

  always_comb begin
    cont_lo = CONT_MIN;
    cont_hi = CONT_MAX;
    unique case (state_i.range_code)
      RANGE_PLAIN: ;
      RANGE_HIGH:  cont_lo = four_byte ? CONT4_HI_MIN : CONT3_HI_MIN;
      RANGE_LOW:   cont_hi = four_byte ? CONT4_LO_MAX : CONT3_LO_MAX;
      default:     ;
    endcase
  end

  assign cont_ok  = (data_byte_i >= cont_lo) && (data_byte_i <= cont_hi);
  assign plain_ok = (data_byte_i == BYTE_TAB) || (data_byte_i == BYTE_LF) ||
                    (data_byte_i == BYTE_CR) ||
                    ((data_byte_i >= BYTE_SPACE) && (data_byte_i <= BYTE_TILDE));

  assign is_term_o = (data_byte_i == BYTE_TERM);
  assign verdict_o = !state_i.error_seen && (state_i.bytes_pending == PEND_NONE);

  always_comb begin
    state_o = state_i;
    priority if (is_term_o) begin
      state_o = '{bytes_pending: PEND_NONE, range_code: RANGE_PLAIN, error_seen: 1'b0};
    end else if (state_i.error_seen) begin
      // sticky until the terminator
    end else if (state_i.bytes_pending != PEND_NONE) begin
      if (cont_ok) begin
        state_o.bytes_pending = state_i.bytes_pending - 2'd1;
        state_o.range_code    = RANGE_PLAIN;
      end else begin
        state_o = '{bytes_pending: PEND_NONE, range_code: RANGE_PLAIN, error_seen: 1'b1};
      end
    end else if (plain_ok) begin
      // single-byte character, nothing pending
    end else if ((data_byte_i >= LEAD2_MIN) && (data_byte_i <= LEAD2_MAX)) begin
      state_o.bytes_pending = 2'd1;
      state_o.range_code    = RANGE_PLAIN;
    end else if ((data_byte_i >= LEAD3_MIN) && (data_byte_i <= LEAD3_MAX)) begin
      state_o.bytes_pending = PEND_TWO;
      state_o.range_code    = (data_byte_i == LEAD3_MIN)  ? RANGE_HIGH :
                              (data_byte_i == LEAD3_SURR) ? RANGE_LOW  : RANGE_PLAIN;
    end else if ((data_byte_i >= LEAD4_MIN) && (data_byte_i <= LEAD4_MAX)) begin
      state_o.bytes_pending = PEND_THREE;
      state_o.range_code    = (data_byte_i == LEAD4_MIN) ? RANGE_HIGH :
                              (data_byte_i == LEAD4_MAX) ? RANGE_LOW  : RANGE_PLAIN;
    end else begin
      state_o = '{bytes_pending: PEND_NONE, range_code: RANGE_PLAIN, error_seen: 1'b1};
    end
  end

endmodule

// File: sim/tb_utf8_stream_validator.sv
// testbench of the utf-8 stream validator: directed strings, random strings, stalls on both sides
`timescale 1ns / 1ps

module tb_utf8_stream_validator;
  import usv_pkg::*;

  // run shape
  localparam int unsigned ITEM_TARGET    = 1550;
  localparam int unsigned QUIET_ITEMS    = 200;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned PRESS_STRINGS  = 30;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 4;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [1:0] PEND_ONE = 2'd1;

  // verdicts as typed into the directed table
  localparam logic VERDICT_OK  = 1'b1;
  localparam logic VERDICT_BAD = 1'b0;
  localparam logic ROW_FIXED   = 1'b1;
  localparam logic ROW_PREDICT = 1'b0;

  // one directed item: the byte and, on some terminators, the verdict read off by eye
  typedef struct packed {
    logic [7:0] data;
    logic       fixed;
    logic       verdict;
  } row_t;

  localparam row_t DIRECTED_ROWS [23] = '{
    // empty string right after reset
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_OK},
    // del is rejected
    '{8'h7F,       ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD},
    // tab and the top printable character
    '{BYTE_TAB,    ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TILDE,  ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_PREDICT, VERDICT_BAD},
    // overlong three-byte form
    '{LEAD3_MIN,   ROW_PREDICT, VERDICT_BAD},
    '{CONT3_LO_MAX, ROW_PREDICT, VERDICT_BAD},
    '{CONT_MIN,    ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD},
    // surrogate
    '{LEAD3_SURR,  ROW_PREDICT, VERDICT_BAD},
    '{CONT3_HI_MIN, ROW_PREDICT, VERDICT_BAD},
    '{CONT_MIN,    ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD},
    // above the top code point
    '{LEAD4_MAX,   ROW_PREDICT, VERDICT_BAD},
    '{CONT4_HI_MIN, ROW_PREDICT, VERDICT_BAD},
    '{CONT_MIN,    ROW_PREDICT, VERDICT_BAD},
    '{CONT_MIN,    ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD},
    // terminator inside a sequence
    '{LEAD2_MIN,   ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD},
    // top byte is never a lead
    '{8'hFF,       ROW_PREDICT, VERDICT_BAD},
    '{BYTE_TERM,   ROW_FIXED,   VERDICT_BAD}
  };

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       data_valid_i   = 1'b0;
  logic [7:0] data_byte_i    = 8'h00;
  logic       data_stall_o;
  logic       result_valid_o;
  logic       string_valid_o;
  logic       result_stall_i = 1'b0;

  // checker state mirrored by the predictor
  logic [1:0] chk_pend  = PEND_NONE;
  range_e     chk_range = RANGE_PLAIN;
  logic       chk_err   = 1'b0;

  logic        expected_verdicts [$];
  logic [7:0]  str_q [$];
  int unsigned n_sent       = 0;
  int unsigned n_verdicts   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  bit          quiet        = 1'b0;  // no idling on either side
  bit          pressing     = 1'b0;  // sender offers back to back
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;

  utf8_stream_validator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_byte_i    (data_byte_i),
    .data_stall_o   (data_stall_o),
    .result_valid_o (result_valid_o),
    .string_valid_o (string_valid_o),
    .result_stall_i (result_stall_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor: advance the utf-8 checker by one byte, returns 1 when a verdict is due
  function automatic logic advance_checker(input logic [7:0] b, output logic verdict);
    logic [7:0] lo;
    logic [7:0] hi;
    verdict = 1'b0;
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (b == BYTE_TERM) begin
      verdict   = !chk_err && (chk_pend == PEND_NONE);
      chk_pend  = PEND_NONE;
      chk_range = RANGE_PLAIN;
      chk_err   = 1'b0;
      return 1'b1;
    end
    // sticky error: everything up to the terminator is ignored
    if (chk_err) return 1'b0;
    if (chk_pend != PEND_NONE) begin
      // first continuation may have a raised floor or a lowered ceiling
      if (chk_range == RANGE_HIGH) begin
        lo = (chk_pend == PEND_THREE) ? CONT4_HI_MIN : CONT3_HI_MIN;
      end else if (chk_range == RANGE_LOW) begin
        hi = (chk_pend == PEND_THREE) ? CONT4_LO_MAX : CONT3_LO_MAX;
      end
      if (b >= lo && b <= hi) begin
        chk_pend  = chk_pend - PEND_ONE;
        chk_range = RANGE_PLAIN;
      end else begin
        chk_err   = 1'b1;
        chk_pend  = PEND_NONE;
        chk_range = RANGE_PLAIN;
      end
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      chk_pend  = PEND_ONE;
      chk_range = RANGE_PLAIN;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      chk_pend  = PEND_TWO;
      chk_range = (b == LEAD3_MIN) ? RANGE_HIGH : (b == LEAD3_SURR) ? RANGE_LOW : RANGE_PLAIN;
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      chk_pend  = PEND_THREE;
      chk_range = (b == LEAD4_MIN) ? RANGE_HIGH : (b == LEAD4_MAX) ? RANGE_LOW : RANGE_PLAIN;
    end else if (!(b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR ||
                   (b >= BYTE_SPACE && b <= BYTE_TILDE))) begin
      // bad lead, stray continuation or forbidden control
      chk_err   = 1'b1;
      chk_pend  = PEND_NONE;
      chk_range = RANGE_PLAIN;
    end
    return 1'b0;
  endfunction

  // legal first continuation after a lead byte
  function automatic logic [7:0] first_cont(input logic [7:0] lead);
    case (lead)
      LEAD3_MIN:  return 8'($urandom_range(CONT3_HI_MIN, CONT_MAX));
      LEAD3_SURR: return 8'($urandom_range(CONT_MIN, CONT3_LO_MAX));
      LEAD4_MIN:  return 8'($urandom_range(CONT4_HI_MIN, CONT_MAX));
      LEAD4_MAX:  return 8'($urandom_range(CONT_MIN, CONT4_LO_MAX));
      default:    return 8'($urandom_range(CONT_MIN, CONT_MAX));
    endcase
  endfunction

  function automatic logic [7:0] any_cont();
    return 8'($urandom_range(CONT_MIN, CONT_MAX));
  endfunction

  function automatic logic [7:0] any_nonzero();
    return 8'($urandom_range(1, 255));
  endfunction

  // append one well-formed character to the string
  task automatic add_char();
    logic [7:0] lead;
    case ($urandom_range(0, 9))
      0, 1, 2: str_q.push_back(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
      3: begin
        case ($urandom_range(0, 2))
          0:       str_q.push_back(BYTE_TAB);
          1:       str_q.push_back(BYTE_LF);
          default: str_q.push_back(BYTE_CR);
        endcase
      end
      4, 5: begin
        lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
        str_q.push_back(lead);
        str_q.push_back(any_cont());
      end
      6, 7: begin
        lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
        str_q.push_back(lead);
        str_q.push_back(first_cont(lead));
        str_q.push_back(any_cont());
      end
      default: begin
        lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
        str_q.push_back(lead);
        str_q.push_back(first_cont(lead));
        str_q.push_back(any_cont());
        str_q.push_back(any_cont());
      end
    endcase
  endtask

  // damage a well-formed string in one of several ways
  task automatic break_string();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: begin
        if (str_q.size() == 0) str_q.push_back(any_nonzero());
        else str_q[$urandom_range(0, str_q.size() - 1)] = any_nonzero();
      end
      1: str_q.insert($urandom_range(0, str_q.size()), any_nonzero());
      2: begin
        // sequence cut short by the terminator
        lead = 8'($urandom_range(LEAD2_MIN, LEAD4_MAX));
        str_q.push_back(lead);
        if (lead >= LEAD3_MIN && $urandom_range(0, 1) == 1) str_q.push_back(first_cont(lead));
      end
      default: begin
        // just outside the limits
        case ($urandom_range(0, 7))
          0: begin str_q.push_back(LEAD3_MIN);  str_q.push_back(CONT3_LO_MAX); end
          1: begin str_q.push_back(LEAD3_SURR); str_q.push_back(CONT3_HI_MIN); end
          2: begin str_q.push_back(LEAD4_MIN);  str_q.push_back(CONT4_LO_MAX); end
          3: begin str_q.push_back(LEAD4_MAX);  str_q.push_back(CONT4_HI_MIN); end
          4: str_q.push_back(8'($urandom_range(CONT_MIN, LEAD2_MIN - 8'd1)));
          5: str_q.push_back(8'($urandom_range(LEAD4_MAX + 8'd1, 8'hFF)));
          6: str_q.push_back(8'h7F);
          default: str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h01, 8'h08))
                                                       : 8'($urandom_range(8'h0E, 8'h1F)));
        endcase
        if ($urandom_range(0, 1) == 1) add_char();
      end
    endcase
  endtask

  // mostly well-formed text, some damaged strings, some pure noise
  task automatic build_string(input int unsigned max_chars);
    int unsigned kind;
    str_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) str_q.push_back(any_nonzero());
    end else begin
      repeat ($urandom_range(0, max_chars)) add_char();
      if (kind <= 3) break_string();
    end
  endtask

  // offer one byte, wait for it to be taken, then predict
  task automatic push_byte(input logic [7:0] b, input logic fixed, input logic fixed_v);
    logic v;
    if (!quiet && !pressing && $urandom_range(0, 5) == 0) begin
      data_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    @(posedge clk_i);
    while (data_stall_o !== 1'b0) @(posedge clk_i);
    n_sent++;
    if (advance_checker(b, v)) expected_verdicts.push_back(fixed ? fixed_v : v);
  endtask

  task automatic send_string();
    foreach (str_q[i]) push_byte(str_q[i], ROW_PREDICT, VERDICT_BAD);
    push_byte(BYTE_TERM, ROW_PREDICT, VERDICT_BAD);
  endtask

  // sender goes idle until every verdict is back
  task automatic drain();
    data_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // byte source
  initial begin : byte_source
    bit paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].verdict);
    end
    drain();

    // long receiver hold while short strings keep coming, so terminators back up
    pressing = 1'b1;
    hold_req = 1'b1;
    repeat (PRESS_STRINGS) begin
      build_string(1);
      send_string();
    end
    pressing = 1'b0;

    while (n_sent < ITEM_TARGET) begin
      if (n_sent + QUIET_ITEMS >= ITEM_TARGET) quiet = 1'b1;
      if (!paused && n_sent >= ITEM_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
      build_string(6);
      send_string();
    end
    data_valid_i <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // verdict sink: checks each taken verdict and drives random stall bursts
  initial begin : verdict_sink
    int unsigned stall_left;
    logic        exp_v;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_valid_o === 1'b1 && !result_stall_i) begin
        n_verdicts++;
        if (expected_verdicts.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("verdict %0d with no string pending: got %b", n_verdicts, string_valid_o);
          end
          mismatch_cnt++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (string_valid_o !== exp_v) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("verdict %0d mismatch: expected %b, got %b",
                       n_verdicts, exp_v, string_valid_o);
            end
            mismatch_cnt++;
          end
        end
      end
      // the one long hold, counted here
      if (hold_req && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done  = 1'b1;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
        result_stall_i <= 1'b1;
        stall_left--;
      end else begin
        result_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk_i) begin
    if ((data_valid_i && data_stall_o === 1'b0) || (result_valid_o === 1'b1 && !result_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
src/usv_pkg.sv
src/usv_step.sv
src/utf8_stream_validator.sv
sim/tb_utf8_stream_validator.sv
